>>> hw/rtl/gpiodb_pkg.sv
// Shared types, codes and constants of the debounced three-port GPIO block.
`default_nettype none
package gpiodb_pkg;

  localparam int PORT_COUNT = 3;
  localparam int PORT_WIDTH = 8;
  localparam int PORT_IDX_W = $clog2(PORT_COUNT);
  localparam int PIN_IDX_W  = $clog2(PORT_WIDTH);

  localparam int FUNC_W     = 4;
  localparam int PSEL_W     = 2;
  localparam int PIN_W      = 4;
  localparam int DATA_W     = 8;
  localparam int RUN_W      = 4;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [PORT_WIDTH-1:0] DIR_RESET   = '1;
  localparam logic [PORT_WIDTH-1:0] LATCH_RESET = '0;
  localparam logic [RUN_W-1:0]      RUN_MAX     = '1;
  localparam logic [RUN_W-1:0]      DEB_RESET   = RUN_W'(5);

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT       = 4'd0,
    FN_SET_DIR    = 4'd1,
    FN_WRITE_PIN  = 4'd2,
    FN_READ_PIN   = 4'd3,
    FN_WRITE_PORT = 4'd4,
    FN_READ_PORT  = 4'd5,
    FN_DEB_PIN    = 4'd6,
    FN_DEB_PORT   = 4'd7,
    FN_SAMPLE     = 4'd8
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INIT_DIR_A   = 3'd0,
    REG_INIT_DIR_B   = 3'd1,
    REG_INIT_DIR_C   = 3'd2,
    REG_INIT_LATCH_A = 3'd3,
    REG_INIT_LATCH_B = 3'd4,
    REG_INIT_LATCH_C = 3'd5,
    REG_DEBOUNCE     = 3'd6
  } reg_idx_e;

  typedef logic [PORT_COUNT-1:0][PORT_WIDTH-1:0] port_vec_t;

  typedef struct packed {
    port_vec_t         init_dir;
    port_vec_t         init_latch;
    logic [RUN_W-1:0]  debounce_count;
  } cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PSEL_W-1:0] port_sel;
    logic [PIN_W-1:0]  pin_index;
    logic [DATA_W-1:0] data_value;
    port_vec_t         pins;
  } item_t;

endpackage
`default_nettype wire

>>> hw/rtl/gpiodb_if.sv
// Valid/ready channel interfaces for access beats and result beats.
`default_nettype none
interface gpiodb_in_if;
  logic                           valid;
  logic                           ready;
  logic [gpiodb_pkg::FUNC_W-1:0]  func;
  logic [gpiodb_pkg::PSEL_W-1:0]  port_sel;
  logic [gpiodb_pkg::PIN_W-1:0]   pin_index;
  logic [gpiodb_pkg::DATA_W-1:0]  data_value;
  logic [gpiodb_pkg::DATA_W-1:0]  pins_a;
  logic [gpiodb_pkg::DATA_W-1:0]  pins_b;
  logic [gpiodb_pkg::DATA_W-1:0]  pins_c;

  modport source (output valid, func, port_sel, pin_index, data_value, pins_a, pins_b,
                  pins_c, input ready);
  modport sink (input valid, func, port_sel, pin_index, data_value, pins_a, pins_b,
                pins_c, output ready);
endinterface

interface gpiodb_out_if;
  logic                           valid;
  logic                           ready;
  logic [gpiodb_pkg::DATA_W-1:0]  read_data;
  logic                           bad_access;

  modport source (output valid, read_data, bad_access, input ready);
  modport sink (input valid, read_data, bad_access, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/gpiodb_apb_regs.sv
// APB configuration registers: init patterns and debounce count.
`default_nettype none
module gpiodb_apb_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gpiodb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [gpiodb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [gpiodb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                    pready,
  output gpiodb_pkg::cfg_t                        cfg
);

  gpiodb_pkg::cfg_t     cfg_r;
  gpiodb_pkg::cfg_t     cfg_nxt;
  gpiodb_pkg::reg_idx_e idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = gpiodb_pkg::reg_idx_e'(paddr[gpiodb_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        gpiodb_pkg::REG_INIT_DIR_A:   cfg_nxt.init_dir[0]   = pwdata[gpiodb_pkg::PORT_WIDTH-1:0];
        gpiodb_pkg::REG_INIT_DIR_B:   cfg_nxt.init_dir[1]   = pwdata[gpiodb_pkg::PORT_WIDTH-1:0];
        gpiodb_pkg::REG_INIT_DIR_C:   cfg_nxt.init_dir[2]   = pwdata[gpiodb_pkg::PORT_WIDTH-1:0];
        gpiodb_pkg::REG_INIT_LATCH_A: cfg_nxt.init_latch[0] = pwdata[gpiodb_pkg::PORT_WIDTH-1:0];
        gpiodb_pkg::REG_INIT_LATCH_B: cfg_nxt.init_latch[1] = pwdata[gpiodb_pkg::PORT_WIDTH-1:0];
        gpiodb_pkg::REG_INIT_LATCH_C: cfg_nxt.init_latch[2] = pwdata[gpiodb_pkg::PORT_WIDTH-1:0];
        gpiodb_pkg::REG_DEBOUNCE:     cfg_nxt.debounce_count = pwdata[gpiodb_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gpiodb_pkg::REG_INIT_DIR_A:   prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.init_dir[0]);
      gpiodb_pkg::REG_INIT_DIR_B:   prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.init_dir[1]);
      gpiodb_pkg::REG_INIT_DIR_C:   prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.init_dir[2]);
      gpiodb_pkg::REG_INIT_LATCH_A: prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.init_latch[0]);
      gpiodb_pkg::REG_INIT_LATCH_B: prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.init_latch[1]);
      gpiodb_pkg::REG_INIT_LATCH_C: prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.init_latch[2]);
      gpiodb_pkg::REG_DEBOUNCE:     prdata = gpiodb_pkg::APB_DATA_W'(cfg_r.debounce_count);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_dir[0]    <= gpiodb_pkg::DIR_RESET;
      cfg_r.init_dir[1]    <= gpiodb_pkg::DIR_RESET;
      cfg_r.init_dir[2]    <= gpiodb_pkg::DIR_RESET;
      cfg_r.init_latch[0]  <= gpiodb_pkg::LATCH_RESET;
      cfg_r.init_latch[1]  <= gpiodb_pkg::LATCH_RESET;
      cfg_r.init_latch[2]  <= gpiodb_pkg::LATCH_RESET;
      cfg_r.debounce_count <= gpiodb_pkg::DEB_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gpiodb_debounce.sv
// Per-port debounce filters: candidate pattern, run counter, filtered pins.
`default_nettype none
module gpiodb_debounce (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire gpiodb_pkg::port_vec_t         raw,
  input  wire logic [gpiodb_pkg::RUN_W-1:0]  debounce_count,
  output gpiodb_pkg::port_vec_t              filt_nxt
);

  gpiodb_pkg::port_vec_t cand_r;
  gpiodb_pkg::port_vec_t cand_nxt;
  gpiodb_pkg::port_vec_t filt_r;
  logic [gpiodb_pkg::PORT_COUNT-1:0][gpiodb_pkg::RUN_W-1:0] run_r;
  logic [gpiodb_pkg::PORT_COUNT-1:0][gpiodb_pkg::RUN_W-1:0] run_nxt;
  logic [gpiodb_pkg::RUN_W-1:0] need;

  // a count of zero behaves as one
  assign need = (debounce_count == '0) ? gpiodb_pkg::RUN_W'(1) : debounce_count;

  always_comb begin
    for (int p = 0; p < gpiodb_pkg::PORT_COUNT; p++) begin
      if (raw[p] == cand_r[p]) begin
        cand_nxt[p] = cand_r[p];
        run_nxt[p]  = (run_r[p] == gpiodb_pkg::RUN_MAX) ? run_r[p]
                                                       : run_r[p] + gpiodb_pkg::RUN_W'(1);
      end else begin
        cand_nxt[p] = raw[p];
        run_nxt[p]  = gpiodb_pkg::RUN_W'(1);
      end
      filt_nxt[p] = (run_nxt[p] >= need) ? cand_nxt[p] : filt_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
      filt_r <= '0;
      run_r  <= '0;
    end else if (step) begin
      cand_r <= cand_nxt;
      filt_r <= filt_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gpiodb_port_ctrl.sv
// Direction and latch registers, access decode and read selection.
`default_nettype none
module gpiodb_port_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire gpiodb_pkg::item_t              item,
  input  wire gpiodb_pkg::port_vec_t          filt,
  input  wire gpiodb_pkg::cfg_t               cfg,
  output logic [gpiodb_pkg::DATA_W-1:0]       read_data,
  output logic                                bad_access
);

  gpiodb_pkg::port_vec_t dir_r;
  gpiodb_pkg::port_vec_t dir_nxt;
  gpiodb_pkg::port_vec_t latch_r;
  gpiodb_pkg::port_vec_t latch_nxt;
  logic                                   port_ok;
  logic                                   pin_ok;
  logic [gpiodb_pkg::PORT_IDX_W-1:0]      ps;
  logic [gpiodb_pkg::PIN_IDX_W-1:0]       pi;
  logic [gpiodb_pkg::PORT_WIDTH-1:0]      dir_sel;
  logic [gpiodb_pkg::PORT_WIDTH-1:0]      latch_sel;
  logic [gpiodb_pkg::PORT_WIDTH-1:0]      pins_sel;
  logic [gpiodb_pkg::PORT_WIDTH-1:0]      filt_sel;

  assign port_ok = item.port_sel < gpiodb_pkg::PSEL_W'(gpiodb_pkg::PORT_COUNT);
  assign pin_ok  = item.pin_index < gpiodb_pkg::PIN_W'(gpiodb_pkg::PORT_WIDTH);
  assign ps      = port_ok ? item.port_sel[gpiodb_pkg::PORT_IDX_W-1:0] : '0;
  assign pi      = item.pin_index[gpiodb_pkg::PIN_IDX_W-1:0];

  assign dir_sel   = dir_r[ps];
  assign latch_sel = latch_r[ps];
  assign pins_sel  = item.pins[ps];
  assign filt_sel  = filt[ps];

  always_comb begin
    dir_nxt    = dir_r;
    latch_nxt  = latch_r;
    read_data  = '0;
    bad_access = 1'b0;
    case (item.func)
      gpiodb_pkg::FN_INIT: begin
        dir_nxt   = cfg.init_dir;
        latch_nxt = cfg.init_latch;
      end
      gpiodb_pkg::FN_SET_DIR: begin
        if (!port_ok || !pin_ok) bad_access = 1'b1;
        else dir_nxt[ps][pi] = item.data_value[0];
      end
      gpiodb_pkg::FN_WRITE_PIN: begin
        if (!port_ok || !pin_ok) bad_access = 1'b1;
        else latch_nxt[ps][pi] = item.data_value[0];
      end
      gpiodb_pkg::FN_READ_PIN: begin
        if (!port_ok || !pin_ok) bad_access = 1'b1;
        else read_data = {{(gpiodb_pkg::DATA_W-1){1'b0}},
                          dir_sel[pi] ? pins_sel[pi] : latch_sel[pi]};
      end
      gpiodb_pkg::FN_WRITE_PORT: begin
        if (!port_ok) bad_access = 1'b1;
        else latch_nxt[ps] = item.data_value[gpiodb_pkg::PORT_WIDTH-1:0];
      end
      gpiodb_pkg::FN_READ_PORT: begin
        if (!port_ok) bad_access = 1'b1;
        else read_data = gpiodb_pkg::DATA_W'((&dir_sel) ? pins_sel : latch_sel);
      end
      gpiodb_pkg::FN_DEB_PIN: begin
        if (!port_ok || !pin_ok) bad_access = 1'b1;
        else read_data = {{(gpiodb_pkg::DATA_W-1){1'b0}},
                          dir_sel[pi] ? filt_sel[pi] : latch_sel[pi]};
      end
      gpiodb_pkg::FN_DEB_PORT: begin
        if (!port_ok) bad_access = 1'b1;
        else read_data = gpiodb_pkg::DATA_W'((&dir_sel) ? filt_sel : latch_sel);
      end
      default: ;  // sample only and unused codes
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < gpiodb_pkg::PORT_COUNT; p++) begin
        dir_r[p]   <= gpiodb_pkg::DIR_RESET;
        latch_r[p] <= gpiodb_pkg::LATCH_RESET;
      end
    end else if (step) begin
      dir_r   <= dir_nxt;
      latch_r <= latch_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gpio_three_port_debounced_top.sv
// Path from input beat to result beat: input register, then result register.
// Throughput: one access beat per cycle while out_bus.ready holds; the filter and the port
// registers update in the cycle an item moves from the input register to the result register.
// Reset (rst_n, synchronous, active low): all pins input, latches and filters zero,
// init registers at their defaults, debounce count 5, both stages empty.
`default_nettype none
module gpio_three_port_debounced_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  gpiodb_in_if.sink                               in_bus,
  gpiodb_out_if.source                            out_bus,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gpiodb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [gpiodb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [gpiodb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                    pready
);

  gpiodb_pkg::cfg_t       cfg;
  gpiodb_pkg::item_t      s1_item_r;
  gpiodb_pkg::item_t      in_item;
  gpiodb_pkg::port_vec_t  filt_nxt;
  logic                   s1_valid_r;
  logic                   advance;
  logic                   out_valid_r;
  logic [gpiodb_pkg::DATA_W-1:0] out_data_r;
  logic                   out_bad_r;
  logic [gpiodb_pkg::DATA_W-1:0] rd_nxt;
  logic                   bad_nxt;

  assign in_item.func       = in_bus.func;
  assign in_item.port_sel   = in_bus.port_sel;
  assign in_item.pin_index  = in_bus.pin_index;
  assign in_item.data_value = in_bus.data_value;
  assign in_item.pins[0]    = in_bus.pins_a;
  assign in_item.pins[1]    = in_bus.pins_b;
  assign in_item.pins[2]    = in_bus.pins_c;

  // move the held item into the result register when that slot frees
  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;

  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_data  = out_data_r;
  assign out_bus.bad_access = out_bad_r;

  gpiodb_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gpiodb_debounce u_deb (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .raw            (s1_item_r.pins),
    .debounce_count (cfg.debounce_count),
    .filt_nxt       (filt_nxt)
  );

  gpiodb_port_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (s1_item_r),
    .filt       (filt_nxt),
    .cfg        (cfg),
    .read_data  (rd_nxt),
    .bad_access (bad_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= rd_nxt;
      out_bad_r  <= bad_nxt;
    end
  end

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_data_r == '0)
    else $error("flagged access carries nonzero read data");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register empty after an item advanced");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> s1_valid_r)
    else $error("input register empty after an accepted beat");

  a_no_flag_init_sample: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_item_r.func == gpiodb_pkg::FN_INIT ||
                s1_item_r.func >= gpiodb_pkg::FN_SAMPLE) |=> !out_bad_r)
    else $error("init or sample item raised the error flag");

endmodule
`default_nettype wire

>>> verif/gpiodb_access_check.sv
// Monitor, access predictor and result comparison for the debounced three-port GPIO block.
`timescale 1ns / 100ps
module gpiodb_access_check
  import gpiodb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  gpiodb_in_if                  in_mon,
  gpiodb_out_if                 out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              bad_access;
  } gpio_result_t;

  logic [PORT_WIDTH-1:0] dir_bits   [PORT_COUNT];
  logic [PORT_WIDTH-1:0] latch_bits [PORT_COUNT];
  logic [PORT_WIDTH-1:0] filt_pins  [PORT_COUNT];
  logic [PORT_WIDTH-1:0] cand_pins  [PORT_COUNT];
  logic [RUN_W-1:0]      run_len    [PORT_COUNT];

  logic [PORT_WIDTH-1:0] init_dir   [PORT_COUNT];
  logic [PORT_WIDTH-1:0] init_latch [PORT_COUNT];
  logic [RUN_W-1:0]      deb_need;

  gpio_result_t read_q[$];

  function automatic logic pin_level(input logic [PORT_WIDTH-1:0] dir,
                                     input logic [PORT_WIDTH-1:0] pins,
                                     input logic [PORT_WIDTH-1:0] latch,
                                     input int unsigned pin);
    return dir[pin] ? pins[pin] : latch[pin];
  endfunction

  function automatic logic [PORT_WIDTH-1:0] port_level(input logic [PORT_WIDTH-1:0] dir,
                                                       input logic [PORT_WIDTH-1:0] pins,
                                                       input logic [PORT_WIDTH-1:0] latch);
    return (dir == '1) ? pins : latch;
  endfunction

  // Run one access beat: filter the pins first, then apply the operation.
  function automatic gpio_result_t predict_access(input item_t it);
    gpio_result_t res;
    logic [RUN_W-1:0] need;
    logic [PORT_WIDTH-1:0] raw;
    logic pin_op;
    logic in_range;
    int unsigned port;
    int unsigned pin;
    res = '0;
    need = (deb_need == '0) ? RUN_W'(1) : deb_need;
    for (int p = 0; p < PORT_COUNT; p++) begin
      raw = it.pins[p];
      if (raw == cand_pins[p]) begin
        if (run_len[p] != RUN_MAX) run_len[p] = run_len[p] + 1'b1;
      end else begin
        cand_pins[p] = raw;
        run_len[p] = RUN_W'(1);
      end
      if (run_len[p] >= need) filt_pins[p] = cand_pins[p];
    end
    port = it.port_sel;
    pin = it.pin_index;
    pin_op = it.func inside {FN_SET_DIR, FN_WRITE_PIN, FN_READ_PIN, FN_DEB_PIN};
    in_range = (port < PORT_COUNT) && (!pin_op || pin < PORT_WIDTH);
    case (it.func)
      FN_INIT: begin
        for (int p = 0; p < PORT_COUNT; p++) begin
          dir_bits[p] = init_dir[p];
          latch_bits[p] = init_latch[p];
        end
      end
      FN_SET_DIR, FN_WRITE_PIN, FN_READ_PIN, FN_WRITE_PORT, FN_READ_PORT,
      FN_DEB_PIN, FN_DEB_PORT: begin
        if (!in_range) begin
          res.bad_access = 1'b1;
        end else begin
          case (it.func)
            FN_SET_DIR:    dir_bits[port][pin] = it.data_value[0];
            FN_WRITE_PIN:  latch_bits[port][pin] = it.data_value[0];
            FN_WRITE_PORT: latch_bits[port] = it.data_value;
            FN_READ_PIN: begin
              res.read_data = DATA_W'(pin_level(dir_bits[port], it.pins[port],
                                                latch_bits[port], pin));
            end
            FN_READ_PORT: begin
              res.read_data = port_level(dir_bits[port], it.pins[port], latch_bits[port]);
            end
            FN_DEB_PIN: begin
              res.read_data = DATA_W'(pin_level(dir_bits[port], filt_pins[port],
                                                latch_bits[port], pin));
            end
            default: begin
              res.read_data = port_level(dir_bits[port], filt_pins[port], latch_bits[port]);
            end
          endcase
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    gpio_result_t got;
    gpio_result_t want;
    item_t it;
    if (!rst_n) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        dir_bits[p] = DIR_RESET;
        latch_bits[p] = LATCH_RESET;
        filt_pins[p] = '0;
        cand_pins[p] = '0;
        run_len[p] = '0;
        init_dir[p] = DIR_RESET;
        init_latch[p] = LATCH_RESET;
      end
      deb_need = DEB_RESET;
      read_q.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[APB_ADDR_W-1:2]))
          REG_INIT_DIR_A:   init_dir[0] = pwdata[PORT_WIDTH-1:0];
          REG_INIT_DIR_B:   init_dir[1] = pwdata[PORT_WIDTH-1:0];
          REG_INIT_DIR_C:   init_dir[2] = pwdata[PORT_WIDTH-1:0];
          REG_INIT_LATCH_A: init_latch[0] = pwdata[PORT_WIDTH-1:0];
          REG_INIT_LATCH_B: init_latch[1] = pwdata[PORT_WIDTH-1:0];
          REG_INIT_LATCH_C: init_latch[2] = pwdata[PORT_WIDTH-1:0];
          REG_DEBOUNCE:     deb_need = pwdata[RUN_W-1:0];
          default: ;
        endcase
      end
      // Compare before pushing so a beat can never match its own prediction.
      if (out_mon.valid && out_mon.ready) begin
        got.read_data = out_mon.read_data;
        got.bad_access = out_mon.bad_access;
        if (read_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no access pending: read_data=%02h bad_access=%0b",
                   $time, got.read_data, got.bad_access);
        end else begin
          want = read_q.pop_front();
          checked++;
          if (got.read_data !== want.read_data) begin
            fail_count++;
            $display("%0t: read_data mismatch: expected %02h, actual %02h",
                     $time, want.read_data, got.read_data);
          end
          if (got.bad_access !== want.bad_access) begin
            fail_count++;
            $display("%0t: bad_access mismatch: expected %0b, actual %0b",
                     $time, want.bad_access, got.bad_access);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.func = in_mon.func;
        it.port_sel = in_mon.port_sel;
        it.pin_index = in_mon.pin_index;
        it.data_value = in_mon.data_value;
        it.pins[0] = in_mon.pins_a;
        it.pins[1] = in_mon.pins_b;
        it.pins[2] = in_mon.pins_c;
        read_q.push_back(predict_access(it));
      end
    end
    pending = read_q.size();
  end

endmodule

>>> verif/tb_top.sv
// Top of the GPIO testbench: clock, reset, register setup, access stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import gpiodb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int TAIL_CYCLES  = 4;
  localparam logic [FUNC_W-1:0] FUNC_CODE_TOP = '1;
  localparam logic [PSEL_W-1:0] PORT_NONE     = '1;
  localparam logic [PIN_W-1:0]  PIN_TOP       = '1;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending_results;
  int results_checked;
  int cycle_count;
  int beats_sent;
  int settings_run;
  bit in_quiet;
  bit out_quiet;
  int hold_span;
  logic [DATA_W-1:0] pin_drive [PORT_COUNT];

  gpiodb_in_if  in_if ();
  gpiodb_out_if out_if ();

  gpio_three_port_debounced_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gpiodb_access_check access_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending_results),
    .checked    (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               CYCLE_LIMIT, pending_results);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: unless out_quiet is set, stall a random number of cycles before each beat.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  function automatic item_t make_item(input logic [FUNC_W-1:0] f,
                                      input logic [PSEL_W-1:0] port,
                                      input logic [PIN_W-1:0] pin,
                                      input logic [DATA_W-1:0] data,
                                      input logic [DATA_W-1:0] a,
                                      input logic [DATA_W-1:0] b,
                                      input logic [DATA_W-1:0] c);
    item_t it;
    it.func = f;
    it.port_sel = port;
    it.pin_index = pin;
    it.data_value = data;
    it.pins[0] = a;
    it.pins[1] = b;
    it.pins[2] = c;
    return it;
  endfunction

  // Hold the pins for a while, then jump to a new pattern or bounce one bit.
  function automatic void drift_pins();
    for (int p = 0; p < PORT_COUNT; p++) begin
      if ($urandom_range(0, hold_span) == 0) begin
        if ($urandom_range(0, 1) == 0) pin_drive[p] = DATA_W'($urandom);
        else pin_drive[p][$urandom_range(0, PORT_WIDTH - 1)] ^= 1'b1;
      end
    end
  endfunction

  function automatic item_t pin_access(input logic [FUNC_W-1:0] f,
                                       input logic [PSEL_W-1:0] port,
                                       input logic [PIN_W-1:0] pin,
                                       input logic [DATA_W-1:0] data);
    drift_pins();
    return make_item(f, port, pin, data, pin_drive[0], pin_drive[1], pin_drive[2]);
  endfunction

  function automatic item_t random_access();
    logic [FUNC_W-1:0] f;
    logic [PSEL_W-1:0] port;
    logic [PIN_W-1:0] pin;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) f = FN_INIT;
    else if (pick < 8) f = FUNC_W'($urandom_range(FN_SAMPLE + 1, FUNC_CODE_TOP));
    else f = FUNC_W'($urandom_range(FN_SET_DIR, FN_SAMPLE));
    port = ($urandom_range(0, 9) == 0) ? PORT_NONE : PSEL_W'($urandom_range(0, PORT_COUNT - 1));
    pin = ($urandom_range(0, 9) == 0) ? PIN_W'($urandom_range(PORT_WIDTH, PIN_TOP))
                                      : PIN_W'($urandom_range(0, PORT_WIDTH - 1));
    return pin_access(f, port, pin, DATA_W'($urandom));
  endfunction

  task automatic send_access(input item_t it);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.func <= it.func;
    in_if.port_sel <= it.port_sel;
    in_if.pin_index <= it.pin_index;
    in_if.data_value <= it.data_value;
    in_if.pins_a <= it.pins[0];
    in_if.pins_b <= it.pins[1];
    in_if.pins_c <= it.pins[2];
    in_if.valid <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [APB_DATA_W-1:0] setting [REG_DEBOUNCE + 1];
    logic [PSEL_W-1:0] port;
    int sent_in_phase;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.func = FN_INIT;
    in_if.port_sel = '0;
    in_if.pin_index = '0;
    in_if.data_value = '0;
    in_if.pins_a = '0;
    in_if.pins_b = '0;
    in_if.pins_c = '0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    hold_span = 8;
    for (int p = 0; p < PORT_COUNT; p++) pin_drive[p] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats on the reset settings.
    send_access(make_item(FN_READ_PORT, 2'd0, 4'd0, 8'h00, 8'hFF, 8'h00, 8'h00));
    send_access(make_item(FN_READ_PIN, 2'd1, 4'd7, 8'h00, 8'h00, 8'h80, 8'h00));
    send_access(make_item(FN_SET_DIR, 2'd2, 4'd0, 8'hFE, 8'h00, 8'h00, 8'hFF));
    send_access(make_item(FN_WRITE_PIN, 2'd2, 4'd0, 8'h01, 8'h00, 8'h00, 8'h00));
    send_access(make_item(FN_READ_PIN, 2'd2, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_access(make_item(FN_READ_PORT, 2'd2, 4'd0, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_access(make_item(FN_WRITE_PORT, 2'd0, 4'd0, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_access(make_item(FN_READ_PORT, 2'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_access(make_item(FN_READ_PORT, PORT_NONE, 4'd0, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_access(make_item(FN_READ_PIN, 2'd0, PIN_TOP, 8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_access(make_item(FN_SET_DIR, 2'd0, PIN_W'(PORT_WIDTH), 8'h00, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FN_WRITE_PORT, PORT_NONE, 4'd0, 8'hAA, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FN_WRITE_PORT, 2'd1, PIN_TOP, 8'h55, 8'h5A, 8'hA5, 8'h3C));
    repeat (5) send_access(make_item(FN_SAMPLE, 2'd0, 4'd0, 8'h00, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FN_DEB_PORT, 2'd0, 4'd0, 8'h00, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FN_DEB_PIN, 2'd0, 4'd1, 8'h00, 8'h00, 8'hA5, 8'h3C));
    send_access(make_item(FN_DEB_PORT, 2'd1, 4'd0, 8'h00, 8'h5A, 8'h00, 8'h3C));
    send_access(make_item(FN_INIT, PORT_NONE, PIN_TOP, 8'hFF, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FUNC_CODE_TOP, PORT_NONE, PIN_TOP, 8'hFF, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FN_DEB_PIN, PORT_NONE, 4'd0, 8'h00, 8'h5A, 8'hA5, 8'h3C));
    send_access(make_item(FN_DEB_PIN, 2'd1, PIN_W'(PORT_WIDTH + 1), 8'h00, 8'h5A, 8'hA5,
                          8'h3C));
    wait_results_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = REG_INIT_DIR_A; r <= REG_DEBOUNCE; r++) setting[r] = $urandom_range(0, 255);
      case (ph)
        0: begin
          for (int r = REG_INIT_DIR_A; r <= REG_INIT_LATCH_C; r++) setting[r] = '0;
          setting[REG_DEBOUNCE] = '0;
        end
        1: begin
          for (int r = REG_INIT_DIR_A; r <= REG_INIT_LATCH_C; r++)
            setting[r] = APB_DATA_W'(8'hFF);
          setting[REG_DEBOUNCE] = APB_DATA_W'(RUN_MAX);
        end
        2: setting[REG_DEBOUNCE] = 1;
        default: setting[REG_DEBOUNCE] = $urandom_range(1, RUN_MAX);
      endcase
      for (int r = REG_INIT_DIR_A; r <= REG_DEBOUNCE; r++) cfg_write(reg_idx_e'(r), setting[r]);
      settings_run++;
      in_quiet = (ph % 3 == 1) || (ph == 4);
      out_quiet = (ph % 3 == 2) || (ph == 4);
      hold_span = (ph % 2 == 0) ? 3 : 20;
      send_access(pin_access(FN_INIT, 2'd0, 4'd0, 8'h00));
      sent_in_phase = 1;
      while (sent_in_phase < PHASE_ITEMS) begin
        if ($urandom_range(0, 39) == 0) begin
          // Turn a whole port into inputs, then read it both ways.
          port = PSEL_W'($urandom_range(0, PORT_COUNT - 1));
          for (int b = 0; b < PORT_WIDTH; b++)
            send_access(pin_access(FN_SET_DIR, port, PIN_W'(b), 8'h01));
          send_access(pin_access(FN_DEB_PORT, port, 4'd0, 8'h00));
          send_access(pin_access(FN_READ_PORT, port, 4'd0, 8'h00));
          sent_in_phase += PORT_WIDTH + 2;
        end else begin
          send_access(random_access());
          sent_in_phase++;
        end
        // Hold the sender at most once per phase, when exactly half the phase has gone out, until every result is back.
        if (sent_in_phase == PHASE_ITEMS / 2) wait_results_drained();
      end
      wait_results_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Sent %0d access beats and checked %0d results over %0d register settings,",
             beats_sent, results_checked, settings_run);
    $display("with bad ports and pins, unused codes and debounce counts from zero to fifteen.");
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending_results);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> gpio_three_port_debounced_top.f
hw/rtl/gpiodb_pkg.sv
hw/rtl/gpiodb_if.sv
hw/rtl/gpiodb_apb_regs.sv
hw/rtl/gpiodb_debounce.sv
hw/rtl/gpiodb_port_ctrl.sv
hw/rtl/gpio_three_port_debounced_top.sv
verif/gpiodb_access_check.sv
verif/tb_top.sv
